@@ rtl/p2p_handshake_flow_classifier_assert.svh @@
// assertion macros for the handshake flow classifier
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef P2P_HANDSHAKE_FLOW_CLASSIFIER_ASSERT_SVH
`define P2P_HANDSHAKE_FLOW_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define P2PHS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("p2phs assertion failed");

// next-cycle implication, checked out of reset
`define P2PHS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("p2phs assertion failed");

`else

`define P2PHS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define P2PHS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/p2phs_pkg.sv @@
// shared types, codes and prefix pattern tables for the handshake flow classifier
// no dependencies
`timescale 1ns / 1ps

package p2phs_pkg;

    localparam int NUM_PAT = 6;
    localparam int PAT_MAX = 11;

    localparam logic [3:0] COUNT_MAX = 4'd15;

    typedef logic [NUM_PAT-1:0] pat_flags_t;

    typedef enum logic [2:0] {
        VERD_PENDING  = 3'd0,
        VERD_HUB      = 3'd1,
        VERD_PEER     = 3'd2,
        VERD_ADC_PEER = 3'd3,
        VERD_EXCLUDED = 3'd4,
        VERD_IGNORED  = 3'd5
    } verdict_t;

    localparam logic [1:0] STAGE_START = 2'd0;
    localparam logic [1:0] STAGE_LOCK  = 2'd1;
    localparam logic [1:0] STAGE_NICK  = 2'd2;

    localparam logic [7:0] CHAR_DOLLAR = "$";
    localparam logic [7:0] CHAR_BAR    = "|";
    localparam logic [7:0] CHAR_LT     = "<";

    // bit 0 lock, bit 1 mynick, bits 2-3 hsup, bits 4-5 csup
    localparam logic [7:0] PAT_TEXT [NUM_PAT][PAT_MAX] = '{
        '{"$", "L", "o", "c", "k", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"$", "M", "y", "N", "i", "c", "k", " ", 8'h00, 8'h00, 8'h00},
        '{"H", "S", "U", "P", " ", "A", "D", "B", "A", "S", "0"},
        '{"H", "S", "U", "P", " ", "A", "D", "B", "A", "S", "E"},
        '{"C", "S", "U", "P", " ", "A", "D", "B", "A", "S", "0"},
        '{"C", "S", "U", "P", " ", "A", "D", "B", "A", "S", "E"}
    };

    localparam logic [3:0] PAT_LEN [NUM_PAT] = '{
        4'd6, 4'd8, 4'd11, 4'd11, 4'd11, 4'd11
    };

    localparam int PAT_LOCK = 0;
    localparam int PAT_NICK = 1;
    localparam pat_flags_t HSUP_MASK = 6'b00_1100;
    localparam pat_flags_t CSUP_MASK = 6'b11_0000;

endpackage

@@ rtl/p2phs_matcher.sv @@
// anchored prefix tracker: drops each pattern that the byte at this offset breaks
// depends on p2phs_pkg
`timescale 1ns / 1ps

module p2phs_matcher
    import p2phs_pkg::*;
(
    input  logic [7:0]  data_byte,
    input  logic [3:0]  pos,
    input  pat_flags_t  flags_in,
    output pat_flags_t  flags_out
);

    always_comb begin
        flags_out = flags_in;
        for (int k = 0; k < NUM_PAT; k++) begin
            if (pos < PAT_LEN[k]) begin
                if (PAT_TEXT[k][pos] != data_byte) begin
                    flags_out[k] = 1'b0;
                end
            end
        end
    end

endmodule

@@ rtl/p2p_handshake_flow_classifier.sv @@
// top level of the handshake flow classifier: flow state, packet trackers, result register
// depends on p2phs_pkg, p2phs_matcher and p2p_handshake_flow_classifier_assert.svh
`timescale 1ns / 1ps

// Takes one payload byte per clock and gives one result per packet end, registered
// in the cycle after the last byte is accepted. Every tcp byte is folded into the flow state
// and packet trackers in the cycle it is accepted, so a byte may enter each cycle;
// s_ready drops only while a finished result waits in the output register and m_ready
// is low. A new flow command clears the state and gives no result.

`include "p2p_handshake_flow_classifier_assert.svh"

module p2p_handshake_flow_classifier
    import p2phs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_of_packet,
    input  logic       s_is_tcp,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_verdict,
    output logic [1:0] m_stage_after
);

    logic [1:0]  stage_reg,    stage_next;
    verdict_t    decision_reg, decision_next;
    logic [3:0]  count_reg,    count_next;
    logic [7:0]  first_reg,    first_next;
    pat_flags_t  flags_reg,    flags_next;
    logic [7:0]  prev_reg,     prev_next;

    logic        m_valid_reg,  m_valid_next;
    verdict_t    verdict_reg,  verdict_next;
    logic [1:0]  stage_out_reg, stage_out_next;

    logic        accept;
    pat_flags_t  flags_match;
    logic [3:0]  count_upd;
    logic [7:0]  first_upd;
    logic        endbar;
    logic        lock_hit;
    logic        nick_hit;
    logic        hsup_hit;
    logic        csup_hit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    p2phs_matcher u_matcher (
        .data_byte (s_data_byte),
        .pos       (count_reg),
        .flags_in  (flags_reg),
        .flags_out (flags_match)
    );

    // packet trackers including the byte at the input
    assign count_upd = (count_reg < COUNT_MAX) ? count_reg + 4'd1 : count_reg;
    assign first_upd = (count_reg == 4'd0) ? s_data_byte : first_reg;
    assign endbar    = (s_data_byte == CHAR_BAR);
    assign lock_hit  = flags_match[PAT_LOCK] && (count_upd > 4'd6);
    assign nick_hit  = flags_match[PAT_NICK] && (count_upd > 4'd7);
    assign hsup_hit  = ((flags_match & HSUP_MASK) != '0) && (count_upd >= 4'd11);
    assign csup_hit  = ((flags_match & CSUP_MASK) != '0) && (count_upd >= 4'd11);

    always_comb begin
        stage_next     = stage_reg;
        decision_next  = decision_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        flags_next     = flags_reg;
        prev_next      = prev_reg;
        verdict_next   = verdict_reg;
        stage_out_next = stage_out_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (accept) begin
            if (s_command) begin
                stage_next    = STAGE_START;
                decision_next = VERD_PENDING;
                count_next    = '0;
                first_next    = '0;
                flags_next    = '1;
                prev_next     = '0;
            end else if (!s_is_tcp) begin
                if (s_last_of_packet) begin
                    count_next     = '0;
                    first_next     = '0;
                    flags_next     = '1;
                    prev_next      = '0;
                    verdict_next   = VERD_IGNORED;
                    stage_out_next = stage_reg;
                    m_valid_next   = 1'b1;
                end
            end else if (!s_last_of_packet) begin
                count_next = count_upd;
                first_next = first_upd;
                flags_next = flags_match;
                prev_next  = s_data_byte;
            end else begin
                if (decision_reg == VERD_PENDING) begin
                    case (stage_reg)
                        STAGE_START: begin
                            if (lock_hit && endbar) begin
                                stage_next = STAGE_LOCK;
                            end else if (nick_hit && endbar) begin
                                stage_next = STAGE_NICK;
                            end else if (hsup_hit) begin
                                decision_next = VERD_HUB;
                            end else if (csup_hit) begin
                                decision_next = VERD_ADC_PEER;
                            end else begin
                                decision_next = VERD_EXCLUDED;
                            end
                        end
                        STAGE_LOCK: begin
                            if (hsup_hit) begin
                                decision_next = VERD_HUB;
                            end else if (csup_hit) begin
                                decision_next = VERD_ADC_PEER;
                            end else if ((count_upd > 4'd6) && endbar &&
                                         (first_upd == CHAR_DOLLAR ||
                                          first_upd == CHAR_LT)) begin
                                decision_next = VERD_HUB;
                            end else begin
                                decision_next = VERD_EXCLUDED;
                            end
                        end
                        STAGE_NICK: begin
                            if ((count_upd > 4'd6) && endbar && first_upd == CHAR_DOLLAR) begin
                                decision_next = VERD_PEER;
                            end else begin
                                decision_next = VERD_EXCLUDED;
                            end
                        end
                        default: begin
                            decision_next = VERD_EXCLUDED;
                        end
                    endcase
                end
                verdict_next   = decision_next;
                stage_out_next = stage_next;
                m_valid_next   = 1'b1;
                count_next     = '0;
                first_next     = '0;
                flags_next     = '1;
                prev_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg    <= STAGE_START;
            decision_reg <= VERD_PENDING;
            count_reg    <= '0;
            first_reg    <= '0;
            flags_reg    <= '1;
            prev_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            stage_reg    <= stage_next;
            decision_reg <= decision_next;
            count_reg    <= count_next;
            first_reg    <= first_next;
            flags_reg    <= flags_next;
            prev_reg     <= prev_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg   <= verdict_next;
        stage_out_reg <= stage_out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_verdict     = verdict_reg;
    assign m_stage_after = stage_out_reg;

    // a decision stays until a new flow starts
    `P2PHS_ASSERT_NEXT(a_decision_final, aclk, aresetn,
        (decision_reg != VERD_PENDING) && !(accept && s_command),
        decision_reg == $past(decision_reg))

    // stage three is never reached
    `P2PHS_ASSERT_SAME(a_stage_legal, aclk, aresetn, 1'b1, stage_reg != 2'd3)

    // a new flow command leaves a clean flow
    `P2PHS_ASSERT_NEXT(a_new_flow_clears, aclk, aresetn, accept && s_command,
        stage_reg == STAGE_START && decision_reg == VERD_PENDING && count_reg == 4'd0)

endmodule

@@ test/flow_verdict_tracker.sv @@
// watches both channels of the handshake flow classifier, predicts every verdict
// and compares it with what the block returns; depends on p2phs_pkg for port codes
`timescale 1ns / 1ps

module flow_verdict_tracker
    import p2phs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_of_packet,
    input  logic        s_is_tcp,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_verdict,
    input  logic [1:0]  m_stage_after,
    output int          mismatches,
    output int unsigned verdicts_owed
);

    localparam logic [7:0] BAR_CHAR    = 8'h7C;
    localparam logic [7:0] DOLLAR_CHAR = 8'h24;
    localparam logic [7:0] LT_CHAR     = 8'h3C;
    localparam logic [5:0] HSUP_BITS   = 6'b00_1100;
    localparam logic [5:0] CSUP_BITS   = 6'b11_0000;

    typedef struct packed {
        verdict_t   verdict;
        logic [1:0] stage;
    } flow_verdict_t;

    string prefix_text [6] = '{"$Lock ", "$MyNick ", "HSUP ADBAS0", "HSUP ADBASE",
                               "CSUP ADBAS0", "CSUP ADBASE"};

    flow_verdict_t owed_q [$];
    int            mismatch_count = 0;
    int unsigned   owed_count = 0;

    // flow state and packet trackers
    logic [1:0] stage;
    verdict_t   decision;
    logic [3:0] byte_cnt;
    logic [7:0] first_b;
    logic [5:0] pattern_alive;
    logic [7:0] last_b;

    assign mismatches    = mismatch_count;
    assign verdicts_owed = owed_count;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void clear_trackers();
        byte_cnt      = 4'd0;
        first_b       = 8'd0;
        pattern_alive = 6'b11_1111;
        last_b        = 8'd0;
    endfunction

    function automatic void start_flow();
        stage    = STAGE_START;
        decision = VERD_PENDING;
        clear_trackers();
    endfunction

    function automatic void classify_packet();
        logic endbar, long_enough, lock_ok, nick_ok, hsup_ok, csup_ok;
        endbar      = (last_b == BAR_CHAR);
        long_enough = (byte_cnt > 4'd6);
        lock_ok     = pattern_alive[0] && long_enough;
        nick_ok     = pattern_alive[1] && (byte_cnt > 4'd7);
        hsup_ok     = (|(pattern_alive & HSUP_BITS)) && (byte_cnt >= 4'd11);
        csup_ok     = (|(pattern_alive & CSUP_BITS)) && (byte_cnt >= 4'd11);
        case (stage)
            STAGE_START: begin
                if (lock_ok && endbar) stage = STAGE_LOCK;
                else if (nick_ok && endbar) stage = STAGE_NICK;
                else if (hsup_ok) decision = VERD_HUB;
                else if (csup_ok) decision = VERD_ADC_PEER;
                else decision = VERD_EXCLUDED;
            end
            STAGE_LOCK: begin
                if (hsup_ok) decision = VERD_HUB;
                else if (csup_ok) decision = VERD_ADC_PEER;
                else if (long_enough && endbar && (first_b == DOLLAR_CHAR || first_b == LT_CHAR))
                    decision = VERD_HUB;
                else decision = VERD_EXCLUDED;
            end
            STAGE_NICK: begin
                if (long_enough && endbar && first_b == DOLLAR_CHAR) decision = VERD_PEER;
                else decision = VERD_EXCLUDED;
            end
            default: begin
                decision = VERD_EXCLUDED;
            end
        endcase
    endfunction

    function automatic void owe_verdict(input verdict_t v);
        flow_verdict_t r;
        r.verdict = v;
        r.stage   = stage;
        owed_q.push_back(r);
    endfunction

    function automatic void absorb_request();
        if (s_command) begin
            start_flow();
        end else if (!s_is_tcp) begin
            if (s_last_of_packet) begin
                clear_trackers();
                owe_verdict(VERD_IGNORED);
            end
        end else begin
            if (byte_cnt == 4'd0) first_b = s_data_byte;
            for (int k = 0; k < 6; k++) begin
                if (byte_cnt < prefix_text[k].len() && prefix_text[k][byte_cnt] != s_data_byte)
                    pattern_alive[k] = 1'b0;
            end
            last_b = s_data_byte;
            if (byte_cnt != 4'd15) byte_cnt++;
            if (s_last_of_packet) begin
                if (decision == VERD_PENDING) classify_packet();
                owe_verdict(decision);
                clear_trackers();
            end
        end
    endfunction

    task automatic check_verdict();
        flow_verdict_t want;
        if (owed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result verdict %0d stage %0d",
                                      m_verdict, m_stage_after));
        end else begin
            want = owed_q.pop_front();
            if (m_verdict !== want.verdict)
                report_mismatch($sformatf("verdict %0d, want %0d", m_verdict, want.verdict));
            if (m_stage_after !== want.stage)
                report_mismatch($sformatf("stage %0d, want %0d", m_stage_after, want.stage));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_flow();
            owed_q.delete();
        end else begin
            if (m_valid && m_ready) check_verdict();
            if (s_valid && s_ready) absorb_request();
        end
        owed_count <= owed_q.size();
    end

endmodule

@@ test/testbench.sv @@
// stimulus and verdict for the handshake flow classifier: drives flows of packets
// depends on p2phs_pkg, p2p_handshake_flow_classifier and flow_verdict_tracker
`timescale 1ns / 1ps

module testbench;
    import p2phs_pkg::*;

    localparam int RANDOM_REQUESTS = 1050;
    localparam int HOLD_CYCLES     = 80;
    localparam int CYCLE_LIMIT     = 200000;

    logic       aclk;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic       s_command        = 1'b0;
    logic [7:0] s_data_byte      = 8'd0;
    logic       s_last_of_packet = 1'b0;
    logic       s_is_tcp         = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic [2:0] m_verdict;
    logic [1:0] m_stage_after;

    int          mismatches;
    int unsigned verdicts_owed;
    int          cycle_count   = 0;
    int          burst_left    = 0;
    int          gap_max       = 0;
    int          requests_sent = 0;
    int          hold_asked    = 0;
    logic [7:0]  pkt [$];

    string prefix_text [6] = '{"$Lock ", "$MyNick ", "HSUP ADBAS0", "HSUP ADBASE",
                               "CSUP ADBAS0", "CSUP ADBASE"};

    p2p_handshake_flow_classifier DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_data_byte      (s_data_byte),
        .s_last_of_packet (s_last_of_packet),
        .s_is_tcp         (s_is_tcp),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict        (m_verdict),
        .m_stage_after    (m_stage_after)
    );

    flow_verdict_tracker u_tracker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_data_byte      (s_data_byte),
        .s_last_of_packet (s_last_of_packet),
        .s_is_tcp         (s_is_tcp),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict        (m_verdict),
        .m_stage_after    (m_stage_after),
        .mismatches       (mismatches),
        .verdicts_owed    (verdicts_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver: ready pattern in spans, plus a long hold when asked
    initial begin
        int mode, span, served;
        served = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(posedge aclk);
                if (hold_asked != served) begin
                    served = hold_asked;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic offer(input logic cmd, input logic [7:0] b, input logic last,
                         input logic tcp);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_data_byte      <= b;
        s_last_of_packet <= last;
        s_is_tcp         <= tcp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        if (cmd || tcp || last) requests_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (verdicts_owed != 0) @(posedge aclk);
    endtask

    function automatic void add_text(input string t);
        for (int i = 0; i < t.len(); i++) pkt.push_back(t[i]);
    endfunction

    function automatic void add_fill(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    // sends pkt as one tcp packet, slipping in a non-tcp request now and then when strays is set
    task automatic send_packet(input bit strays);
        for (int i = 0; i < pkt.size(); i++) begin
            if (strays && $urandom_range(0, 39) == 0)
                offer(1'b0, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
            offer(1'b0, pkt[i], (i == pkt.size() - 1), 1'b1);
        end
    endtask

    task automatic send_text(input string t);
        pkt.delete();
        add_text(t);
        send_packet(1'b0);
    endtask

    function automatic void build_packet();
        int kind, k, cut;
        pkt.delete();
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1: begin
                add_text("$Lock ");
                add_fill($urandom_range(0, 5));
                add_text("|");
            end
            2, 3: begin
                add_text("$MyNick ");
                add_fill($urandom_range(0, 4));
                add_text("|");
            end
            4, 5, 6: begin
                add_text(kind == 6 ? "CSUP ADBAS" : "HSUP ADBAS");
                case ($urandom_range(0, 4))
                    0: pkt.push_back(8'($urandom));
                    1, 2: add_text("0");
                    default: add_text("E");
                endcase
                add_fill($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1) add_text("|");
            end
            7, 8: begin
                add_text($urandom_range(0, 1) ? "$" : "<");
                add_fill($urandom_range(3, 8));
                add_text("|");
            end
            9: begin
                k = $urandom_range(0, 5);
                cut = $urandom_range(1, prefix_text[k].len());
                for (int i = 0; i < cut; i++) pkt.push_back(prefix_text[k][i]);
                if ($urandom_range(0, 1) == 1) add_text("|");
            end
            10: begin
                add_fill($urandom_range(1, 12));
            end
            default: begin
                add_text($urandom_range(0, 1) ? "$" : "HSUP ADBASE");
                add_fill($urandom_range(15, 25));
                add_text("|");
            end
        endcase
        if ($urandom_range(0, 7) == 0) begin
            k = $urandom_range(0, pkt.size() - 1);
            pkt[k] = pkt[k] ^ (8'd1 << $urandom_range(0, 7));
        end
    endfunction

    task automatic random_flow();
        int packets;
        if ($urandom_range(0, 7) != 0)
            offer(1'b1, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        packets = $urandom_range(1, 4);
        repeat (packets) begin
            build_packet();
            send_packet(1'b1);
        end
    endtask

    // stimulus and verdict
    initial begin
        int next_phase;
        bit held;
        held = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, ignored packet, exclusion, nick path to peer
        offer(1'b1, 8'hFF, 1'b1, 1'b1);
        offer(1'b0, 8'hFF, 1'b1, 1'b0);
        offer(1'b0, 8'hFF, 1'b0, 1'b1);
        offer(1'b0, 8'h00, 1'b1, 1'b1);
        offer(1'b0, 8'h00, 1'b1, 1'b1);
        offer(1'b1, 8'h00, 1'b0, 1'b0);
        send_text("$MyNick |");
        send_text("$abcde|");
        drain();

        requests_sent = 0;
        next_phase = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            if (requests_sent >= next_phase) begin
                drain();
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 10;
                endcase
                next_phase = requests_sent + $urandom_range(120, 250);
            end
            if (!held && requests_sent > 500) begin
                // long receiver hold while requests keep coming
                held = 1'b1;
                drain();
                gap_max = 0;
                hold_asked++;
                repeat (10) begin
                    pkt.delete();
                    add_fill($urandom_range(1, 2));
                    send_packet(1'b0);
                end
            end
            random_flow();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
